FILE: rtl/udppd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udppd_pkg
// Shared types and constants of the UDP port demultiplexer slot table.
// ----------------------------------------------------------------------------
package udppd_pkg;

	// widths of the word fields
	localparam int PORT_W  = 16;
	localparam int IP_W    = 32;
	localparam int LEN_W   = 16;
	localparam int BUF_W   = 3;
	localparam int LINK_W  = 2;
	localparam int SLOT_W  = 3;

	// widest internal link and slot index over the parameter ranges
	localparam int LINK_CAP_W = 3;
	localparam int SLOT_CAP_W = 6;

	// configuration port
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int NUM_CFG    = 4;

	localparam logic KIND_DGRAM   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_UNREACH  = 2'd0,
		ST_NO_SLOT  = 2'd1,
		ST_ACCEPTED = 2'd2,
		ST_RELEASED = 2'd3
	} status_t;

	typedef struct packed {
		logic                  port_hit;
		logic                  slot_hit;
		logic [LINK_CAP_W-1:0] link;
		logic [SLOT_CAP_W-1:0] slot;
	} lookup_t;

endpackage
`default_nettype wire

FILE: rtl/udppd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udppd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module udppd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

FILE: rtl/udppd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udppd_cfg
// Register bank holding the UDP port bound to each link.
// ----------------------------------------------------------------------------
module udppd_cfg #(
	parameter int LINKS = 4
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [udppd_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire logic [udppd_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic      [udppd_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                      pready,
	output logic      [LINKS-1:0][udppd_pkg::PORT_W-1:0] bound_port
);
	import udppd_pkg::*;

	logic [NUM_CFG-1:0][PORT_W-1:0] port_q;
	logic [1:0]                     reg_idx;
	logic                           wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= '0;
		end else if (wr_en && (4'(reg_idx) < 4'(LINKS))) begin
			port_q[reg_idx] <= pwdata[PORT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (4'(reg_idx) < 4'(LINKS)) begin
			prdata = CFG_DATA_W'(port_q[reg_idx]);
		end
	end

	// links beyond the register set stay bound to port 0
	always_comb begin
		for (int l = 0; l < LINKS; l++) begin
			bound_port[l] = (l < NUM_CFG) ? port_q[2'(l)] : '0;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/udppd_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udppd_lookup
// Port match over the links and lowest free slot search of the matched link.
// ----------------------------------------------------------------------------
module udppd_lookup #(
	parameter int LINKS = 4,
	parameter int SLOTS = 8
) (
	input  wire logic [LINKS-1:0][udppd_pkg::PORT_W-1:0] bound_port,
	input  wire logic [LINKS-1:0][SLOTS-1:0]             slot_free,
	input  wire logic [udppd_pkg::PORT_W-1:0]            dest_port,
	output udppd_pkg::lookup_t                           res
);
	import udppd_pkg::*;

	logic [SLOTS-1:0] row;

	always_comb begin
		res.port_hit = 1'b0;
		res.slot_hit = 1'b0;
		res.link     = '0;
		res.slot     = '0;
		row          = '0;
		// lowest link wins
		for (int l = LINKS - 1; l >= 0; l--) begin
			if (bound_port[l] == dest_port) begin
				res.port_hit = 1'b1;
				res.link     = LINK_CAP_W'(l);
				row          = slot_free[l];
			end
		end
		for (int s = SLOTS - 1; s >= 0; s--) begin
			if (row[s]) begin
				res.slot_hit = 1'b1;
				res.slot     = SLOT_CAP_W'(s);
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/udp_port_demux_slot_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// udp_port_demux_slot_table
// UDP destination port demultiplexer with a per-link receive slot table.
// ----------------------------------------------------------------------------
// Takes one word per clock while the output is not stalled and no clearing pass
// runs, and returns one result word per input word through the input register,
// then the result register. Port match and free-slot search are combinational
// compares; slot records live in two RAMs with registered read, read by a
// release in the cycle it leaves the input register. After reset a clearing pass
// writes zero to every address of the peer port and length RAM; s_tready stays
// low while it runs, and configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module udp_port_demux_slot_table #(
	parameter int LINKS = 4,
	parameter int SLOTS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// input words
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// dest_port, peer_port, peer_ip, datagram_length, release_link, release_slot
	input  wire logic [87:0] s_tdata,
	// kind
	input  wire logic [0:0]  s_tuser,
	// result words
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// link_index, slot_index, buffer_index, rec_peer_port, rec_peer_ip, rec_length
	output logic [71:0]      m_tdata,
	// status
	output logic [1:0]       m_tuser
);
	import udppd_pkg::*;

	localparam int LW        = (LINKS > 1) ? $clog2(LINKS) : 1;
	localparam int SW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int AW        = LW + SW;
	localparam int RAM_DEPTH = 2 ** AW;
	localparam int PL_W      = PORT_W + LEN_W;
	localparam int IB_W      = IP_W + BUF_W;

	logic [LINKS-1:0][PORT_W-1:0] bound_port;
	logic [LINKS-1:0][SLOTS-1:0]  slot_free_q;
	logic [SW-1:0]                next_buf_q;
	logic                         clr_busy_q;
	logic [AW-1:0]                clr_addr_q;

	// input register
	logic              s1_valid_q;
	logic              s1_kind;
	logic [PORT_W-1:0] s1_dest_port;
	logic [PORT_W-1:0] s1_peer_port;
	logic [IP_W-1:0]   s1_peer_ip;
	logic [LEN_W-1:0]  s1_length;
	logic [LINK_W-1:0] s1_rel_link;
	logic [SLOT_W-1:0] s1_rel_slot;

	// result register
	logic              s2_valid_q;
	status_t           s2_status;
	logic [LINK_W-1:0] s2_link;
	logic [SLOT_W-1:0] s2_slot;
	logic [BUF_W-1:0]  s2_buf;
	logic              s2_rec;

	lookup_t           lk;
	logic              s1_adv;
	logic              is_rel;
	logic              rel_ok;
	logic              do_acc;
	logic              do_rd;
	logic [LW-1:0]     acc_link;
	logic [SW-1:0]     acc_slot;
	logic [LW-1:0]     rel_link;
	logic [SW-1:0]     rel_slot;
	logic [AW-1:0]     acc_addr;
	logic [AW-1:0]     rel_addr;
	logic [BUF_W-1:0]  cur_buf;
	status_t           res_status;
	logic [LINK_W-1:0] res_link;
	logic [SLOT_W-1:0] res_slot;
	logic [BUF_W-1:0]  res_buf;
	logic              pl_we;
	logic [AW-1:0]     pl_waddr;
	logic [PL_W-1:0]   pl_wdata;
	logic [PL_W-1:0]   pl_rdata;
	logic [IB_W-1:0]   ib_rdata;

	udppd_cfg #(.LINKS(LINKS)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.bound_port(bound_port)
	);

	udppd_lookup #(.LINKS(LINKS), .SLOTS(SLOTS)) u_lookup (
		.bound_port(bound_port),
		.slot_free (slot_free_q),
		.dest_port (s1_dest_port),
		.res       (lk)
	);

	// handshake
	assign s1_adv   = s1_valid_q && (!s2_valid_q || m_tready);
	assign s_tready = !clr_busy_q && (!s1_valid_q || s1_adv);
	assign m_tvalid = s2_valid_q;

	// decode of the held word
	assign is_rel   = (s1_kind == KIND_RELEASE);
	assign rel_ok   = (4'(s1_rel_link) < 4'(LINKS)) && (7'(s1_rel_slot) < 7'(SLOTS));
	assign do_acc   = !is_rel && lk.port_hit && lk.slot_hit;
	assign do_rd    = s1_adv && is_rel && rel_ok;
	assign acc_link = lk.link[LW-1:0];
	assign acc_slot = lk.slot[SW-1:0];
	assign rel_link = LW'(s1_rel_link);
	assign rel_slot = SW'(s1_rel_slot);
	assign acc_addr = {acc_link, acc_slot};
	assign rel_addr = {rel_link, rel_slot};
	assign cur_buf  = BUF_W'(SLOT_CAP_W'(next_buf_q));

	always_comb begin
		res_status = ST_UNREACH;
		res_link   = '0;
		res_slot   = '0;
		res_buf    = '0;
		if (is_rel) begin
			res_status = ST_RELEASED;
			res_link   = s1_rel_link;
			res_slot   = s1_rel_slot;
		end else if (lk.port_hit) begin
			res_link = LINK_W'(lk.link);
			if (lk.slot_hit) begin
				res_status = ST_ACCEPTED;
				res_slot   = SLOT_W'(lk.slot);
				res_buf    = cur_buf;
			end else begin
				res_status = ST_NO_SLOT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			s1_kind      <= s_tuser[0];
			s1_dest_port <= s_tdata[15:0];
			s1_peer_port <= s_tdata[31:16];
			s1_peer_ip   <= s_tdata[63:32];
			s1_length    <= s_tdata[79:64];
			s1_rel_link  <= s_tdata[81:80];
			s1_rel_slot  <= s_tdata[84:82];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (!s2_valid_q || m_tready) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s2_status <= res_status;
			s2_link   <= res_link;
			s2_slot   <= res_slot;
			s2_buf    <= res_buf;
			s2_rec    <= is_rel && rel_ok;
		end
	end

	// slot table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_free_q <= '1;
			next_buf_q  <= '0;
		end else if (s1_adv) begin
			if (do_acc) begin
				slot_free_q[acc_link][acc_slot] <= 1'b0;
				next_buf_q <= (next_buf_q == SW'(SLOTS - 1)) ? '0 : next_buf_q + 1'b1;
			end
			if (is_rel && rel_ok) begin
				slot_free_q[rel_link][rel_slot] <= 1'b1;
			end
		end
	end

	// clearing pass of the peer port and length record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign pl_we    = clr_busy_q || (s1_adv && do_acc);
	assign pl_waddr = clr_busy_q ? clr_addr_q : acc_addr;
	assign pl_wdata = clr_busy_q ? '0 : {s1_length, s1_peer_port};

	udppd_ram #(.WIDTH(PL_W), .DEPTH(RAM_DEPTH)) u_ram_pl (
		.clk  (clk),
		.we   (pl_we),
		.waddr(pl_waddr),
		.wdata(pl_wdata),
		.re   (do_rd),
		.raddr(rel_addr),
		.rdata(pl_rdata)
	);

	udppd_ram #(.WIDTH(IB_W), .DEPTH(RAM_DEPTH)) u_ram_ib (
		.clk  (clk),
		.we   (s1_adv && do_acc),
		.waddr(acc_addr),
		.wdata({cur_buf, s1_peer_ip}),
		.re   (do_rd),
		.raddr(rel_addr),
		.rdata(ib_rdata)
	);

	// result word
	assign m_tuser        = s2_status;
	assign m_tdata[1:0]   = s2_link;
	assign m_tdata[4:2]   = s2_slot;
	assign m_tdata[7:5]   = s2_rec ? ib_rdata[IB_W-1:IP_W] : s2_buf;
	assign m_tdata[23:8]  = s2_rec ? pl_rdata[PORT_W-1:0] : '0;
	assign m_tdata[55:24] = s2_rec ? ib_rdata[IP_W-1:0] : '0;
	assign m_tdata[71:56] = s2_rec ? pl_rdata[PL_W-1:PORT_W] : '0;

	a_clr_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("input accepted during clearing pass");

	a_state_holds_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(slot_free_q) && $stable(next_buf_q))
		else $error("slot table changed with no word processed");

	a_rec_only_release: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != ST_RELEASED)) |-> (m_tdata[71:8] == '0))
		else $error("record fields set on a non-release result");

	a_acc_takes_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && do_acc) |-> slot_free_q[acc_link][acc_slot])
		else $error("accepted datagram given a slot that is not free");
endmodule
`default_nettype wire

FILE: tb/tb_udp_port_demux_slot_table.sv
// ----------------------------------------------------------------------------
// tb_udp_port_demux_slot_table
// Self-checking bench for the UDP port demultiplexer slot table.
// ----------------------------------------------------------------------------
// Binds ports to the four links over the register port, then streams datagram
// arrivals and slot releases into the block. A predictor keeps its own copy of
// the port bindings, the per-link slot table and the buffer counter, and works
// out the answer to every accepted word. Answers leaving the block are checked
// in order against it. A directed part covers the special cases; random
// traffic then runs under several idle and stall mixes, with one long
// receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module tb_udp_port_demux_slot_table;
	timeunit 1ns;
	timeprecision 1ps;

	import udppd_pkg::*;

	localparam int LINK_COUNT  = 4;
	localparam int SLOT_COUNT  = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;

	localparam int REG_PORT_LINK0 = 0;
	localparam int REG_PORT_LINK1 = 1;
	localparam int REG_PORT_LINK2 = 2;
	localparam int REG_PORT_LINK3 = 3;

	// fields from the lowest bit up: link, slot, buffer, peer port, peer ip, length
	typedef struct packed {
		status_t     status;
		logic [15:0] len;
		logic [31:0] ip;
		logic [15:0] pport;
		logic [2:0]  bufidx;
		logic [2:0]  slot;
		logic [1:0]  link;
	} slot_answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [1:0]  m_tuser;

	// predictor state
	logic [15:0] bound_port [LINK_COUNT];
	bit          slot_open  [LINK_COUNT][SLOT_COUNT];
	bit          slot_used  [LINK_COUNT][SLOT_COUNT];
	logic [15:0] rec_pport  [LINK_COUNT][SLOT_COUNT];
	logic [31:0] rec_ip     [LINK_COUNT][SLOT_COUNT];
	logic [2:0]  rec_buf    [LINK_COUNT][SLOT_COUNT];
	logic [15:0] rec_len    [LINK_COUNT][SLOT_COUNT];
	logic [2:0]  buf_next;

	slot_answer_t awaited_answers [$];

	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	udp_port_demux_slot_table #(
		.LINKS(LINK_COUNT),
		.SLOTS(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk) begin
		m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : answer_check
		slot_answer_t got;
		slot_answer_t want;
		if (m_tvalid && m_tready) begin
			got = slot_answer_t'({m_tuser, m_tdata});
			if (awaited_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: st=%0d link=%0d slot=%0d buf=%0d pp=%h ip=%h len=%h",
						got.status, got.link, got.slot, got.bufidx, got.pport, got.ip, got.len);
			end else begin
				want = awaited_answers.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: st=%0d link=%0d slot=%0d buf=%0d pp=%h ip=%h len=%h",
							want.status, want.link, want.slot, want.bufidx, want.pport,
							want.ip, want.len);
						$display("         got: st=%0d link=%0d slot=%0d buf=%0d pp=%h ip=%h len=%h",
							got.status, got.link, got.slot, got.bufidx, got.pport,
							got.ip, got.len);
					end
				end
			end
		end
	end

	task automatic predict_slot_answer(input logic k, input logic [87:0] w);
		slot_answer_t r;
		logic [15:0]  dport;
		logic [15:0]  pport;
		logic [15:0]  len;
		logic [31:0]  ip;
		logic [1:0]   rl;
		logic [2:0]   rs;
		int           l;
		int           s;
		{rs, rl, len, ip, pport, dport} = w[84:0];
		r = '0;
		if (k == KIND_RELEASE) begin
			r.status = ST_RELEASED;
			r.link = rl;
			r.slot = rs;
			r.bufidx = rec_buf[rl][rs];
			r.pport = rec_pport[rl][rs];
			r.ip = rec_ip[rl][rs];
			r.len = rec_len[rl][rs];
			slot_open[rl][rs] = 1'b1;
		end else begin
			l = 0;
			while (l < LINK_COUNT && bound_port[l] != dport)
				l++;
			if (l == LINK_COUNT) begin
				r.status = ST_UNREACH;
			end else begin
				s = 0;
				while (s < SLOT_COUNT && !slot_open[l][s])
					s++;
				r.link = l[1:0];
				if (s == SLOT_COUNT) begin
					r.status = ST_NO_SLOT;
				end else begin
					r.status = ST_ACCEPTED;
					r.slot = s[2:0];
					r.bufidx = buf_next;
					slot_open[l][s] = 1'b0;
					slot_used[l][s] = 1'b1;
					rec_pport[l][s] = pport;
					rec_ip[l][s] = ip;
					rec_buf[l][s] = buf_next;
					rec_len[l][s] = len;
					buf_next = (buf_next == SLOT_COUNT - 1) ? 3'd0 : buf_next + 3'd1;
				end
			end
		end
		awaited_answers.push_back(r);
	endtask

	task automatic send_word(input logic k, input logic [87:0] w);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= k;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_slot_answer(k, w);
	endtask

	task automatic send_dgram(input logic [15:0] dport, input logic [15:0] pport,
		input logic [31:0] ip, input logic [15:0] len);
		logic [2:0] rs;
		logic [1:0] rl;
		rs = 3'($urandom_range(7));
		rl = 2'($urandom_range(3));
		send_word(KIND_DGRAM, {3'b000, rs, rl, len, ip, pport, dport});
	endtask

	task automatic send_release(input logic [1:0] rl, input logic [2:0] rs);
		logic [15:0] dport;
		logic [15:0] pport;
		logic [15:0] len;
		logic [31:0] ip;
		dport = 16'($urandom_range(16'hFFFF));
		pport = 16'($urandom_range(16'hFFFF));
		len = 16'($urandom_range(16'hFFFF));
		ip = $urandom;
		send_word(KIND_RELEASE, {3'b000, rs, rl, len, ip, pport, dport});
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (awaited_answers.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input int idx, input logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx[1:0], 2'b00};
		pwdata <= {16'h0000, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		bound_port[idx] = v;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random_item();
		int held [$];
		int used [$];
		int pick;
		for (int i = 0; i < LINK_COUNT * SLOT_COUNT; i++) begin
			if (slot_used[i / SLOT_COUNT][i % SLOT_COUNT]) begin
				used.push_back(i);
				if (!slot_open[i / SLOT_COUNT][i % SLOT_COUNT])
					held.push_back(i);
			end
		end
		if (used.size() != 0 && $urandom_range(99) < 35) begin
			if (held.size() != 0 && $urandom_range(99) < 85)
				pick = held[$urandom_range(held.size() - 1)];
			else
				pick = used[$urandom_range(used.size() - 1)];
			send_release(2'(pick / SLOT_COUNT), 3'(pick % SLOT_COUNT));
		end else if ($urandom_range(99) < 20) begin
			send_dgram(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)), $urandom,
				16'($urandom_range(16'hFFFF)));
		end else begin
			send_dgram(bound_port[$urandom_range(LINK_COUNT - 1)],
				16'($urandom_range(16'hFFFF)), $urandom, 16'($urandom_range(16'hFFFF)));
		end
	endtask

	// every link bound to port 0 out of reset, so link 0 takes it
	task automatic test_reset_binding();
		send_dgram(16'h0000, 16'h0001, 32'h0A000001, 16'd8);
		send_dgram(16'h0001, 16'h0002, 32'h0A000002, 16'd9);
		wait_drain();
	endtask

	task automatic test_directed();
		apb_write(REG_PORT_LINK0, 16'hFFFF);
		apb_write(REG_PORT_LINK1, 16'h0000);
		apb_write(REG_PORT_LINK2, 16'h1234);
		apb_write(REG_PORT_LINK3, 16'h1234);
		send_dgram(16'hFFFF, 16'h0000, 32'h00000000, 16'h0000);
		send_dgram(16'h0000, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF);
		// shared port, lower link wins
		send_dgram(16'h1234, 16'h8000, 32'hC0A80001, 16'h0040);
		send_dgram(16'h5555, 16'h0101, 32'h7F000001, 16'h0010);
		// fill link 1, buffer counter wraps on the way
		for (int i = 0; i < SLOT_COUNT - 1; i++)
			send_dgram(16'h0000, 16'(i), $urandom, 16'(100 + i));
		send_dgram(16'h0000, 16'h4444, 32'h01020304, 16'h0020);
		send_release(2'd1, 3'd0);
		// release of a slot already free
		send_release(2'd1, 3'd0);
		send_dgram(16'h0000, 16'h7777, 32'h08080808, 16'h0200);
		send_release(2'd1, 3'd7);
		send_release(2'd0, 3'd0);
		send_release(2'd2, 3'd0);
		wait_drain();
	endtask

	task automatic test_traffic(input int n, input int idle_in, input int stall_in,
		input logic [15:0] p0, input logic [15:0] p1, input logic [15:0] p2,
		input logic [15:0] p3);
		wait_drain();
		apb_write(REG_PORT_LINK0, p0);
		apb_write(REG_PORT_LINK1, p1);
		apb_write(REG_PORT_LINK2, p2);
		apb_write(REG_PORT_LINK3, p3);
		send_idle_pct = idle_in;
		recv_stall_pct = stall_in;
		repeat (n) send_random_item();
		wait_drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req <= hold_req + 1;
		repeat (40) send_random_item();
		wait_drain();
	endtask

	initial begin
		for (int l = 0; l < LINK_COUNT; l++) begin
			bound_port[l] = '0;
			for (int s = 0; s < SLOT_COUNT; s++) begin
				slot_open[l][s] = 1'b1;
				slot_used[l][s] = 1'b0;
				rec_pport[l][s] = '0;
				rec_ip[l][s] = '0;
				rec_buf[l][s] = '0;
				rec_len[l][s] = '0;
			end
		end
		buf_next = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_binding();
		test_directed();
		test_traffic(375, 0, 0, 16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
		test_traffic(375, 81, 0, 16'h0000, 16'hFFFF, 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)));
		test_traffic(375, 0, 81, 16'h0007, 16'h0007, 16'h0007, 16'h0007);
		test_traffic(375, 20, 20, 16'($urandom_range(16'hFFFF)),
			16'($urandom_range(16'hFFFF)), 16'hFFFF, 16'h0000);
		test_backpressure();

		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: udp_port_demux_slot_table.f
rtl/udppd_pkg.sv
rtl/udppd_ram.sv
rtl/udppd_cfg.sv
rtl/udppd_lookup.sv
rtl/udp_port_demux_slot_table.sv
tb/tb_udp_port_demux_slot_table.sv
